>>> sv/lds_pkg.sv
// Shared types and constants for the LOOK disk request scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package lds_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int FIELD_W         = 16;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	typedef enum logic [1:0] {
		ST_ADDED    = 2'd0,
		ST_FULL     = 2'd1,
		ST_SELECTED = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic [FIELD_W-1:0] track;
		logic [FIELD_W-1:0] id;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} cmp_ctl_t;

endpackage
`default_nettype wire

>>> sv/lds_nearest.sv
// Nearest-request tracker for one select scan: keeps the best entry on the
// sweep side and on the opposite side. Depends on lds_pkg.
`default_nettype none
module lds_nearest #(
	parameter int AW = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lds_pkg::cmp_ctl_t       ctl,
	input  wire logic [AW-1:0]           idx,
	input  wire lds_pkg::entry_t         ent,
	input  wire logic [lds_pkg::FIELD_W-1:0] head,
	input  wire logic                    dir,
	output logic [AW-1:0]                pick_idx,
	output lds_pkg::entry_t              pick_ent
);
	import lds_pkg::*;

	logic               pf_found_q, op_found_q;
	logic [FIELD_W-1:0] pf_dist_q, op_dist_q;
	logic [AW-1:0]      pf_idx_q, op_idx_q;
	entry_t             pf_ent_q, op_ent_q;

	logic               ge, le, pf_ok, op_ok, pf_take, op_take;
	logic [FIELD_W-1:0] up_d, dn_d, pf_d, op_d;

	always_comb begin
		ge      = ent.track >= head;
		le      = ent.track <= head;
		up_d    = ent.track - head;
		dn_d    = head - ent.track;
		pf_ok   = (dir == DIR_DOWN) ? le : ge;
		op_ok   = (dir == DIR_DOWN) ? ge : le;
		pf_d    = (dir == DIR_DOWN) ? dn_d : up_d;
		op_d    = (dir == DIR_DOWN) ? up_d : dn_d;
		pf_take = ctl.vld && pf_ok && (!pf_found_q || pf_d < pf_dist_q);
		op_take = ctl.vld && op_ok && (!op_found_q || op_d < op_dist_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_found_q <= 1'b0;
			op_found_q <= 1'b0;
		end else if (ctl.clr) begin
			pf_found_q <= 1'b0;
			op_found_q <= 1'b0;
		end else begin
			if (pf_take) pf_found_q <= 1'b1;
			if (op_take) op_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pf_take) begin
			pf_dist_q <= pf_d;
			pf_idx_q  <= idx;
			pf_ent_q  <= ent;
		end
		if (op_take) begin
			op_dist_q <= op_d;
			op_idx_q  <= idx;
			op_ent_q  <= ent;
		end
	end

	assign pick_idx = pf_found_q ? pf_idx_q : op_idx_q;
	assign pick_ent = pf_found_q ? pf_ent_q : op_ent_q;

endmodule
`default_nettype wire

>>> sv/look_disk_request_scheduler.sv
// LOOK disk request scheduler. An add loads its result into the output
// register as it is accepted. A select with N pending requests does one
// memory read per entry for the nearest search, then one read and write per
// entry behind the chosen one to close the gap, both paced by the single read
// port of the request memory. One item is in work at a time; the output
// register holds a result until taken. Depends on lds_pkg and lds_nearest.
`default_nettype none
module look_disk_request_scheduler #(
	parameter int QUEUE_DEPTH = lds_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// request_id[15:0], request_track[31:16], head_position[47:32],
	// sweep_direction[48], zero[55:49]
	input  wire logic [55:0] s_tdata,
	// command[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// chosen_id[15:0], chosen_track[31:16]
	output logic [31:0]      m_tdata,
	// status[1:0]
	output logic [1:0]       m_tuser
);
	import lds_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q, rd_ptr_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	entry_t             rdata_s1;
	logic [FIELD_W-1:0] head_q;
	logic               dir_q;
	logic               out_vld_q;
	entry_t             out_ent_q;
	status_t            out_st_q;

	entry_t             mem [QUEUE_DEPTH];

	logic               in_acc, in_cmd, out_free, rd_fire, phase_end, full, out_set;
	entry_t             in_ent, wdata;
	logic [AW-1:0]      raddr, waddr, pick_idx;
	logic               we;
	entry_t             pick_ent;
	cmp_ctl_t           cmp_ctl;

	always_comb begin
		out_free     = !out_vld_q || m_tready;
		s_tready     = (state_q == S_IDLE) && out_free;
		in_acc       = s_tvalid && s_tready;
		in_cmd       = s_tuser[0];
		in_ent.id    = s_tdata[15:0];
		in_ent.track = s_tdata[31:16];
		full         = cnt_q >= CW'(QUEUE_DEPTH);
		rd_fire      = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_ptr_q < cnt_q);
		phase_end    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && !rd_fire && !vld_s1;
		out_set      = ((state_q == S_IDLE) && in_acc && ((in_cmd == CMD_ADD) || (cnt_q == '0)))
			|| ((state_q == S_DONE) && out_free);
		raddr        = rd_ptr_q[AW-1:0];
		if (state_q == S_SHIFT) begin
			we    = vld_s1;
			waddr = idx_s1 - AW'(1);
			wdata = rdata_s1;
		end else begin
			we    = in_acc && (in_cmd == CMD_ADD) && !full;
			waddr = cnt_q[AW-1:0];
			wdata = in_ent;
		end
		cmp_ctl.clr = in_acc;
		cmp_ctl.vld = vld_s1 && (state_q == S_SCAN);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
		idx_s1   <= raddr;
	end

	lds_nearest #(.AW(AW)) u_nearest (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cmp_ctl),
		.idx      (idx_s1),
		.ent      (rdata_s1),
		.head     (head_q),
		.dir      (dir_q),
		.pick_idx (pick_idx),
		.pick_ent (pick_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_ptr_q  <= '0;
			vld_s1    <= 1'b0;
			head_q    <= '0;
			dir_q     <= 1'b0;
			out_vld_q <= 1'b0;
			out_ent_q <= '0;
			out_st_q  <= ST_ADDED;
		end else begin
			vld_s1 <= rd_fire;
			if (rd_fire) rd_ptr_q <= rd_ptr_q + CW'(1);
			if (out_vld_q && m_tready && !out_set) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_cmd == CMD_ADD) begin
							out_vld_q <= 1'b1;
							out_ent_q <= '0;
							out_st_q  <= full ? ST_FULL : ST_ADDED;
							if (!full) cnt_q <= cnt_q + CW'(1);
						end else if (cnt_q == '0) begin
							out_vld_q <= 1'b1;
							out_ent_q <= '0;
							out_st_q  <= ST_EMPTY;
						end else begin
							head_q   <= s_tdata[47:32];
							dir_q    <= s_tdata[48];
							rd_ptr_q <= '0;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (phase_end) begin
						rd_ptr_q <= CW'(pick_idx) + CW'(1);
						state_q  <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (phase_end) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						out_ent_q <= pick_ent;
						out_st_q  <= ST_SELECTED;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_ent_q.track, out_ent_q.id};
	assign m_tuser  = out_st_q;

endmodule
`default_nettype wire

>>> sv/lds_checker.sv
// Port-level checks for look_disk_request_scheduler, attached by bind.
// Depends on lds_pkg; follows pending requests from result transactions.
`default_nettype none
module lds_checker #(
	parameter int QUEUE_DEPTH = lds_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [55:0] s_tdata,
	input wire logic [0:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import lds_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] pend_q;
	logic          m_acc;

	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (m_acc) begin
			if (m_tuser == ST_ADDED) pend_q <= pend_q + CW'(1);
			else if (m_tuser == ST_SELECTED) pend_q <= pend_q - CW'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ADDED || m_tuser == ST_FULL || m_tuser == ST_EMPTY)
		|-> m_tdata == '0)
		else $error("non-select result carries data");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && m_tuser == ST_FULL |-> pend_q == CW'(QUEUE_DEPTH))
		else $error("full reported below capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && m_tuser == ST_EMPTY |-> pend_q == '0)
		else $error("empty reported with requests pending");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && (m_tuser == ST_ADDED || m_tuser == ST_SELECTED)
		|-> (m_tuser == ST_ADDED && pend_q != CW'(QUEUE_DEPTH))
		 || (m_tuser == ST_SELECTED && pend_q != '0))
		else $error("add past capacity or select from empty store");

endmodule

bind look_disk_request_scheduler lds_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

>>> test/look_disk_request_scheduler_tb.sv
// Self-checking testbench for look_disk_request_scheduler: a directed run, then
// about 2000 random add and select transactions under random stalls on both sides.
// Depends on lds_pkg and the RTL of the block; a local class predicts every result.
`default_nettype none
module look_disk_request_scheduler_tb;
	import lds_pkg::*;

	localparam int DEPTH          = QUEUE_DEPTH_DEF;
	localparam int ITEM_COUNT     = 2000;
	localparam int IDLE_LIMIT     = 4000;
	localparam int HOLDOFF_AT     = 500;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_AT       = 1200;
	localparam int SETTLE_CYCLES  = 60;

	typedef struct {
		status_t     status;
		logic [15:0] id;
		logic [15:0] track;
	} outcome_t;

	class look_tracker;
		logic [15:0] queued_track[$];
		logic [15:0] queued_id[$];
		outcome_t    due[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		function int nearest(int head, bit upward);
			int best;
			int pick;
			int span;
			int t;
			best = 1 << 16;
			pick = -1;
			foreach (queued_track[i]) begin
				t = queued_track[i];
				if (upward) begin
					if (t < head)
						continue;
					span = t - head;
				end else begin
					if (t > head)
						continue;
					span = head - t;
				end
				if (span < best) begin
					best = span;
					pick = i;
				end
			end
			return pick;
		endfunction

		function void note_request(logic cmd, logic [15:0] rid, logic [15:0] rtrack,
				logic [15:0] head, logic dir);
			outcome_t o;
			int pick;
			o.status = ST_ADDED;
			o.id     = '0;
			o.track  = '0;
			if (cmd == CMD_ADD) begin
				if (queued_track.size() >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					queued_track.insert(queued_track.size(), rtrack);
					queued_id.insert(queued_id.size(), rid);
				end
			end else if (queued_track.size() == 0) begin
				o.status = ST_EMPTY;
			end else begin
				pick = nearest(head, dir == DIR_UP);
				if (pick < 0)
					pick = nearest(head, dir != DIR_UP);
				o.status = ST_SELECTED;
				o.id     = queued_id[pick];
				o.track  = queued_track[pick];
				queued_track.delete(pick);
				queued_id.delete(pick);
			end
			due.insert(due.size(), o);
		endfunction

		function void check_result(logic [1:0] st, logic [15:0] cid, logic [15:0] ctrack);
			outcome_t o;
			if (due.size() == 0) begin
				$display("%0t unexpected transaction: status %0d id %h track %h",
					$time, st, cid, ctrack);
				errors++;
				return;
			end
			o = due[0];
			due.delete(0);
			if (st !== o.status) begin
				$display("%0t status: expected %0d actual %0d", $time, o.status, st);
				errors++;
			end
			if (cid !== o.id) begin
				$display("%0t chosen_id: expected %h actual %h", $time, o.id, cid);
				errors++;
			end
			if (ctrack !== o.track) begin
				$display("%0t chosen_track: expected %h actual %h", $time, o.track, ctrack);
				errors++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	look_tracker tracker = new();
	int          accepted_in = 0;
	int          idle_cycles = 0;
	int          burst_left  = 0;
	int          sent_count  = 0;
	bit          holdoff_done = 1'b0;

	look_disk_request_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_result(m_tuser, m_tdata[15:0], m_tdata[31:16]);
			if (s_tvalid && s_tready) begin
				tracker.note_request(s_tuser[0], s_tdata[15:0], s_tdata[31:16],
					s_tdata[47:32], s_tdata[48]);
				accepted_in++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// receiver: random stall pattern, one long hold-off to back the block up
	initial begin
		int mode;
		forever begin
			if (!holdoff_done && accepted_in >= HOLDOFF_AT) begin
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				if (mode == 0) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(30, 80)) @(posedge clk);
				end else begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 8)) @(posedge clk);
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 5)) @(posedge clk);
				end
			end
		end
	end

	task automatic send_item(logic cmd, logic [15:0] rid, logic [15:0] rtrack,
			logic [15:0] head, logic dir);
		int gap;
		bit drain;
		s_tdata  <= {7'b0, dir, head, rtrack, rid};
		s_tuser  <= cmd;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sent_count++;
		drain = (sent_count == DRAIN_AT);
		gap = 0;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
		if (gap > 0 || drain)
			s_tvalid <= 1'b0;
		if (gap > 0)
			repeat (gap) @(posedge clk);
		// hold until the scheduler has answered everything
		if (drain) begin
			@(posedge clk);
			while (tracker.pending() != 0)
				@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_value(logic [15:0] centre);
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = centre + 16'($urandom_range(0, 15)) - 16'd8;
			4, 5:       v = 16'($urandom);
			6:          v = 16'h0000;
			7:          v = 16'hFFFF;
			default:    v = 16'($urandom_range(0, 31));
		endcase
		return v;
	endfunction

	initial begin
		logic [15:0] dir_tracks [DEPTH];
		logic [15:0] centre;
		int          add_pct;
		logic        cmd;
		dir_tracks = '{16'h0000, 16'hFFFF, 16'd100, 16'd100, 16'd90, 16'd110,
			16'd5000, 16'd4999, 16'd5001, 16'd30000, 16'd65534, 16'd1,
			16'd100, 16'd32768, 16'd32767, 16'd7};
		centre  = '0;
		add_pct = 50;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'h0000, DIR_UP);
		send_item(CMD_ADD, 16'hFFFF, dir_tracks[0], 16'($urandom),
			1'($urandom_range(0, 1)));
		send_item(CMD_ADD, 16'h0000, dir_tracks[1], 16'($urandom),
			1'($urandom_range(0, 1)));
		for (int k = 2; k < DEPTH; k++)
			send_item(CMD_ADD, 16'(k), dir_tracks[k], 16'($urandom),
				1'($urandom_range(0, 1)));
		send_item(CMD_ADD, 16'h5A5A, 16'hA5A5, 16'($urandom), 1'($urandom_range(0, 1)));
		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'hFFFF, DIR_UP);
		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'd100, DIR_DOWN);
		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'd100, DIR_UP);
		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'h0000, DIR_DOWN);
		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'hFFFF, DIR_UP);
		send_item(CMD_SELECT, 16'($urandom), 16'($urandom), 16'd95, DIR_DOWN);

		for (int i = 0; i < ITEM_COUNT; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(0, 3))
					0:       add_pct = 35;
					1:       add_pct = 50;
					2:       add_pct = 65;
					default: add_pct = 85;
				endcase
				centre = 16'($urandom);
			end
			cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_SELECT;
			send_item(cmd, 16'($urandom), pick_value(centre), pick_value(centre),
				1'($urandom_range(0, 1)));
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
